FILE: rtl/core/pict_pkg.sv
// shared types, constants and helper functions for the instance conflict tracker
package pict_pkg;

  // instance-carrying parameter group numbers
  localparam logic [17:0] PGN_ENGINE_DYN  = 18'd127488;
  localparam logic [17:0] PGN_SWITCH_CTL  = 18'd127502;
  localparam logic [17:0] PGN_FLUID_LEVEL = 18'd127505;
  localparam logic [17:0] PGN_BATTERY     = 18'd127508;
  localparam logic [17:0] PGN_TEMP        = 18'd130312;
  localparam logic [17:0] PGN_PRESSURE    = 18'd130314;
  localparam logic [17:0] PGN_HEADING_CTL = 18'd127245;

  // instance value meaning untracked
  localparam logic [7:0] INST_NONE = 8'd255;

  // saturation limits of the conflict totals
  localparam logic [5:0] GROUP_MAX  = 6'd63;
  localparam logic [6:0] SOURCE_MAX = 7'd127;

  // one received message
  typedef struct packed {
    logic [17:0] pgn;
    logic [7:0]  source;
    logic [7:0]  data_len;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
  } in_item_t;

  // one result
  typedef struct packed {
    logic        tracked;
    logic [7:0]  instance_num;
    logic        dropped_full;
    logic [5:0]  group_count;
    logic [6:0]  conflict_sources;
    logic        source_conflicts;
  } out_item_t;

  // one table entry
  typedef struct packed {
    logic [17:0] pgn;
    logic [7:0]  source;
    logic [7:0]  inst;
  } entry_t;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_WRITE,
    ST_SCAN,
    ST_OUT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic search_step;
    logic write;
    logic scan_step;
    logic out_load;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic trk;
    logic search_done;
    logic fits;
    logic scan_done;
  } dp_status_t;

  // pgn carries an instance field
  function automatic logic has_instance(input logic [17:0] p);
    return (p == PGN_ENGINE_DYN) || (p == PGN_SWITCH_CTL) || (p == PGN_FLUID_LEVEL) ||
           (p == PGN_BATTERY) || (p == PGN_TEMP) || (p == PGN_PRESSURE) ||
           (p == PGN_HEADING_CTL);
  endfunction

  // instance byte selection, untracked when the payload is too short
  function automatic logic [7:0] pick_instance(input logic [17:0] p, input logic [7:0] len,
                                               input logic [7:0] b0, input logic [7:0] b1);
    logic [7:0] r;
    r = b0;
    if (len == 8'd0) begin
      r = INST_NONE;
    end else if ((p == PGN_TEMP) || (p == PGN_PRESSURE)) begin
      r = (len >= 8'd2) ? b1 : INST_NONE;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/pict_if.sv
// valid/ready channels for messages and results
interface pict_in_if;
  logic                 valid;
  logic                 ready;
  pict_pkg::in_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pict_out_if;
  logic                 valid;
  logic                 ready;
  pict_pkg::out_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/pict_ctrl.sv
// controller state machine for the instance conflict tracker
module pict_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  pict_pkg::dp_status_t status,
  output pict_pkg::ctl_cmd_t   cmd
);

  pict_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  // state and result valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pict_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    in_ready      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      pict_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = pict_pkg::ST_SEARCH;
        end
      end
      pict_pkg::ST_SEARCH: begin
        if (!status.trk) begin
          state_nxt = pict_pkg::ST_OUT;
        end else begin
          cmd.search_step = 1'b1;
          if (status.search_done) begin
            state_nxt = pict_pkg::ST_WRITE;
          end
        end
      end
      pict_pkg::ST_WRITE: begin
        cmd.write = 1'b1;
        state_nxt = status.fits ? pict_pkg::ST_SCAN : pict_pkg::ST_OUT;
      end
      pict_pkg::ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_done) begin
          state_nxt = pict_pkg::ST_OUT;
        end
      end
      pict_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = pict_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pict_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/core/pict_datapath.sv
// entry table, lookup, pairwise rescan and result register
module pict_datapath #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pict_pkg::ctl_cmd_t   cmd,
  input  pict_pkg::in_item_t   in_item,
  output pict_pkg::dp_status_t status,
  output pict_pkg::out_item_t  out_item
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // entry table memory
  pict_pkg::entry_t mem [TABLE_DEPTH];
  pict_pkg::entry_t rd_a_r, rd_b_r;

  // captured message
  logic [17:0] pgn_r;
  logic [7:0]  src_r;
  logic [7:0]  inst_r;
  logic        trk_r;

  // table fill and scan counters
  logic [CW-1:0] fill_r;
  logic [CW-1:0] a_r, i_r, j_r;

  // read pipeline stage
  logic          s1_vld_r;
  logic [IW-1:0] s1_i_r, s1_j_r;
  logic          s1_last_r;

  // lookup and rescan results
  logic          hit_r;
  logic [IW-1:0] hit_idx_r;
  logic          tracked_r, dropped_r;
  logic          any_r, bef_r;
  logic [255:0]  map_r;
  logic [5:0]    grp_r;
  logic [6:0]    srct_r;

  pict_pkg::out_item_t out_r;

  logic          search_issue, scan_issue, last_j, fits;
  logic          pair_match, any_now, bef_now;
  logic [IW-1:0] addr_a, addr_b, wr_addr;
  logic [7:0]    new_inst;

  // address selection and pair compare
  always_comb begin
    new_inst     = pict_pkg::pick_instance(in_item.pgn, in_item.data_len,
                                           in_item.byte0, in_item.byte1);
    last_j       = (j_r == (fill_r - ONE_C));
    search_issue = cmd.search_step && (a_r < fill_r);
    scan_issue   = cmd.scan_step && (i_r < fill_r);
    fits         = hit_r || (fill_r < DEPTH_C);
    addr_a       = cmd.scan_step ? i_r[IW-1:0] : a_r[IW-1:0];
    addr_b       = j_r[IW-1:0];
    wr_addr      = hit_r ? hit_idx_r : fill_r[IW-1:0];
    pair_match   = s1_vld_r && (s1_j_r != s1_i_r) && (rd_a_r.pgn == rd_b_r.pgn) &&
                   (rd_a_r.inst == rd_b_r.inst);
    any_now      = any_r || pair_match;
    bef_now      = bef_r || (pair_match && (s1_j_r < s1_i_r));
  end

  // table write and registered reads
  always_ff @(posedge clk) begin
    if (cmd.write && fits) begin
      mem[wr_addr] <= '{pgn: pgn_r, source: src_r, inst: inst_r};
    end
    rd_a_r <= mem[addr_a];
    rd_b_r <= mem[addr_b];
  end

  // message capture and stage indexes
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pgn_r  <= in_item.pgn;
      src_r  <= in_item.source;
      inst_r <= new_inst;
    end
    if (search_issue) begin
      s1_i_r <= a_r[IW-1:0];
    end
    if (scan_issue) begin
      s1_i_r    <= i_r[IW-1:0];
      s1_j_r    <= j_r[IW-1:0];
      s1_last_r <= last_j;
    end
    if (cmd.search_step && s1_vld_r && !hit_r && (rd_a_r.pgn == pgn_r) &&
        (rd_a_r.source == src_r)) begin
      hit_idx_r <= s1_i_r;
    end
  end

  // control state: lookup, insert and rescan
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_r     <= 1'b0;
      fill_r    <= '0;
      a_r       <= '0;
      i_r       <= '0;
      j_r       <= '0;
      s1_vld_r  <= 1'b0;
      hit_r     <= 1'b0;
      tracked_r <= 1'b0;
      dropped_r <= 1'b0;
      any_r     <= 1'b0;
      bef_r     <= 1'b0;
      map_r     <= '0;
      grp_r     <= '0;
      srct_r    <= '0;
    end else begin
      s1_vld_r <= search_issue || scan_issue;

      // new message
      if (cmd.load) begin
        trk_r     <= pict_pkg::has_instance(in_item.pgn) && (new_inst != pict_pkg::INST_NONE);
        a_r       <= '0;
        hit_r     <= 1'b0;
        tracked_r <= 1'b0;
        dropped_r <= 1'b0;
      end

      // lookup of the (pgn, source) key
      if (search_issue) begin
        a_r <= a_r + ONE_C;
      end
      if (cmd.search_step && s1_vld_r && (rd_a_r.pgn == pgn_r) && (rd_a_r.source == src_r)) begin
        hit_r <= 1'b1;
      end

      // insert or overwrite; when it fits, restart the conflict totals
      if (cmd.write) begin
        tracked_r <= fits;
        dropped_r <= !fits;
        i_r       <= '0;
        j_r       <= '0;
        any_r     <= 1'b0;
        bef_r     <= 1'b0;
        if (fits) begin
          map_r  <= '0;
          grp_r  <= '0;
          srct_r <= '0;
          if (!hit_r) begin
            fill_r <= fill_r + ONE_C;
          end
        end
      end

      // pair address walk
      if (scan_issue) begin
        if (last_j) begin
          j_r <= '0;
          i_r <= i_r + ONE_C;
        end else begin
          j_r <= j_r + ONE_C;
        end
      end

      // per-entry conflict accumulation and finish
      if (cmd.scan_step && s1_vld_r) begin
        if (s1_last_r) begin
          any_r <= 1'b0;
          bef_r <= 1'b0;
          if (any_now) begin
            if (!map_r[rd_a_r.source]) begin
              map_r[rd_a_r.source] <= 1'b1;
              if (srct_r != pict_pkg::SOURCE_MAX) begin
                srct_r <= srct_r + 7'd1;
              end
            end
            if (!bef_now && (grp_r != pict_pkg::GROUP_MAX)) begin
              grp_r <= grp_r + 6'd1;
            end
          end
        end else begin
          any_r <= any_now;
          bef_r <= bef_now;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.tracked          <= tracked_r;
      out_r.instance_num     <= tracked_r ? inst_r : pict_pkg::INST_NONE;
      out_r.dropped_full     <= dropped_r;
      out_r.group_count      <= grp_r;
      out_r.conflict_sources <= srct_r;
      out_r.source_conflicts <= map_r[src_r];
    end
  end

  // status to the controller
  always_comb begin
    status.trk         = trk_r;
    status.search_done = (a_r >= fill_r) && !s1_vld_r;
    status.fits        = fits;
    status.scan_done   = (i_r >= fill_r) && !s1_vld_r;
  end

  assign out_item = out_r;

endmodule

FILE: rtl/core/pgn_instance_conflict_tracker_unit.sv
// top level of the pgn instance conflict tracker
//
// in_ch carries one received message per item (pgn, source, data_len, byte0, byte1);
// out_ch returns exactly one result item per message. Both are valid/ready channels.
// A message with an instance-carrying pgn and a usable instance is looked up in the
// entry table by (pgn, source), written in place or appended, and then the whole table
// is rescanned pairwise for (pgn, instance) groups held by more than one source.
// The pairwise walk reads entry pairs through the two read ports of the entry table.
// A new key that does not fit in a full table is refused without a rescan; a message
// that is not tracked goes straight to its result.
// One message is worked on at a time; in_ch.ready is high only while idle.
// The result register lets the next message be taken while a result waits; if the
// receiver stalls longer, the block holds its finished result until out_ch frees up.
// Reset empties the table through its fill count and clears the conflict totals and
// the source set; no clearing pass over the table is needed.
module pgn_instance_conflict_tracker_unit #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  pict_in_if.sink    in_ch,
  pict_out_if.source out_ch
);

  pict_pkg::ctl_cmd_t   cmd;
  pict_pkg::dp_status_t status;
  logic                 in_ready;
  logic                 out_valid;
  pict_pkg::out_item_t  out_item;

  // controller
  pict_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // datapath
  pict_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_ch.data),
    .status   (status),
    .out_item (out_item)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_item;

`ifndef ASSERT_OFF
  // one message at a time: no new item right after one is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("item accepted while a message is in work");

  // a message is either recorded or refused, never both
  a_tracked_xor_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.data.tracked && out_ch.data.dropped_full))
    else $error("result both tracked and dropped");

  // an untracked result reports the no-instance code
  a_untracked_inst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.data.tracked) |-> (out_ch.data.instance_num == pict_pkg::INST_NONE))
    else $error("untracked result with an instance");

  // a result is only loaded when the output register is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_ch.valid || out_ch.ready))
    else $error("result overwritten before it was taken");
`endif

endmodule

FILE: tb/sv/tb_pgn_instance_conflict_tracker_unit.sv
// testbench for the pgn instance conflict tracker: directed and random messages against a predictor
`timescale 1ns / 100ps

// predicts the tracker's report for each accepted message and checks the results in order
class tracker_scoreboard #(int DEPTH = 64);
  bit                  slot_used [DEPTH];
  logic [17:0]         slot_pgn  [DEPTH];
  logic [7:0]          slot_src  [DEPTH];
  logic [7:0]          slot_inst [DEPTH];
  bit [255:0]          conflict_srcs;
  logic [5:0]          group_total;
  logic [6:0]          source_total;
  pict_pkg::out_item_t expected_reports [$];
  int unsigned         errors;

  function new();
    foreach (slot_used[i]) slot_used[i] = 1'b0;
    conflict_srcs = '0;
    group_total   = '0;
    source_total  = '0;
    errors        = 0;
  endfunction

  // instance carried by a message, none when the pgn has none or the payload is short
  function logic [7:0] extract_inst(pict_pkg::in_item_t m);
    bit tp;
    tp = (m.pgn == pict_pkg::PGN_TEMP) || (m.pgn == pict_pkg::PGN_PRESSURE);
    if (!tp && m.pgn != pict_pkg::PGN_ENGINE_DYN && m.pgn != pict_pkg::PGN_SWITCH_CTL &&
        m.pgn != pict_pkg::PGN_FLUID_LEVEL && m.pgn != pict_pkg::PGN_BATTERY &&
        m.pgn != pict_pkg::PGN_HEADING_CTL)
      return pict_pkg::INST_NONE;
    if (m.data_len == 8'd0) return pict_pkg::INST_NONE;
    if (tp) return (m.data_len >= 8'd2) ? m.byte1 : pict_pkg::INST_NONE;
    return m.byte0;
  endfunction

  // pairwise walk for (pgn, instance) groups with more than one entry
  function void rescan_conflicts();
    int unsigned groups;
    int unsigned srcs;
    bit          earlier;
    bit          shared;
    groups = 0;
    conflict_srcs = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!slot_used[i]) continue;
      earlier = 1'b0;
      shared  = 1'b0;
      for (int j = 0; j < DEPTH; j++) begin
        if (j == i || !slot_used[j]) continue;
        if (slot_pgn[j] == slot_pgn[i] && slot_inst[j] == slot_inst[i]) begin
          shared = 1'b1;
          if (j < i) earlier = 1'b1;
        end
      end
      if (shared) begin
        conflict_srcs[slot_src[i]] = 1'b1;
        if (!earlier) groups++;
      end
    end
    srcs = $countones(conflict_srcs);
    group_total  = (groups > pict_pkg::GROUP_MAX) ? pict_pkg::GROUP_MAX : groups[5:0];
    source_total = (srcs > pict_pkg::SOURCE_MAX) ? pict_pkg::SOURCE_MAX : srcs[6:0];
  endfunction

  function int fill_level();
    int n;
    n = 0;
    foreach (slot_used[i]) if (slot_used[i]) n++;
    return n;
  endfunction

  function bit holds_key(logic [17:0] p, logic [7:0] s);
    foreach (slot_used[i])
      if (slot_used[i] && slot_pgn[i] == p && slot_src[i] == s) return 1'b1;
    return 1'b0;
  endfunction

  function int outstanding();
    return expected_reports.size();
  endfunction

  // update the table for one accepted message and queue its report
  function void note_message(pict_pkg::in_item_t m);
    pict_pkg::out_item_t rpt;
    logic [7:0]          inst;
    int                  hit;
    int                  spare;
    rpt = '0;
    rpt.instance_num = pict_pkg::INST_NONE;
    inst = extract_inst(m);
    if (inst != pict_pkg::INST_NONE) begin
      hit   = -1;
      spare = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i]) begin
          if (hit < 0 && slot_pgn[i] == m.pgn && slot_src[i] == m.source) hit = i;
        end else if (spare < 0) begin
          spare = i;
        end
      end
      if (hit < 0) hit = spare;
      if (hit < 0) begin
        rpt.dropped_full = 1'b1;
      end else begin
        slot_used[hit] = 1'b1;
        slot_pgn[hit]  = m.pgn;
        slot_src[hit]  = m.source;
        slot_inst[hit] = inst;
        rpt.tracked      = 1'b1;
        rpt.instance_num = inst;
        rescan_conflicts();
      end
    end
    rpt.group_count      = group_total;
    rpt.conflict_sources = source_total;
    rpt.source_conflicts = conflict_srcs[m.source];
    expected_reports.push_back(rpt);
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // compare one result with the oldest queued report
  function void check_result(pict_pkg::out_item_t got);
    pict_pkg::out_item_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: result %h with no report queued", $time, got);
      errors++;
      return;
    end
    want = expected_reports.pop_front();
    compare_field("tracked", want.tracked, got.tracked);
    compare_field("instance_num", want.instance_num, got.instance_num);
    compare_field("dropped_full", want.dropped_full, got.dropped_full);
    compare_field("group_count", want.group_count, got.group_count);
    compare_field("conflict_sources", want.conflict_sources, got.conflict_sources);
    compare_field("source_conflicts", want.source_conflicts, got.source_conflicts);
  endfunction
endclass

module tb_pgn_instance_conflict_tracker_unit;
  localparam int DEPTH = 64;
  localparam int RANDOM_ITEMS = 112;
  localparam int PHASE_LEN = 28;
  localparam int POOL_SIZE = 16;
  localparam longint unsigned LIMIT_CYCLES = 64'd3000000;
  localparam logic [17:0] INST_PGNS [7] = '{pict_pkg::PGN_ENGINE_DYN,
                                            pict_pkg::PGN_SWITCH_CTL,
                                            pict_pkg::PGN_FLUID_LEVEL,
                                            pict_pkg::PGN_BATTERY, pict_pkg::PGN_TEMP,
                                            pict_pkg::PGN_PRESSURE,
                                            pict_pkg::PGN_HEADING_CTL};

  logic clk;
  logic rst_n;
  pict_in_if  msg_ch ();
  pict_out_if res_ch ();

  tracker_scoreboard #(DEPTH) board;
  logic [7:0]        src_pool [POOL_SIZE];
  int unsigned       send_gap_pct;
  int unsigned       stall_pct;
  longint unsigned   cycle_count = 0;

  pgn_instance_conflict_tracker_unit #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (msg_ch),
    .out_ch(res_ch)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stalls set at the falling edge
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready = rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  // result check at the rising edge
  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready) board.check_result(res_ch.data);
  end

  function automatic pict_pkg::in_item_t message_of(logic [17:0] p, logic [7:0] s,
                                                    logic [7:0] len, logic [7:0] b0,
                                                    logic [7:0] b1);
    pict_pkg::in_item_t m;
    m.pgn      = p;
    m.source   = s;
    m.data_len = len;
    m.byte0    = b0;
    m.byte1    = b1;
    return m;
  endfunction

  // message with a usable instance, mostly from a small range so groups collide
  function automatic pict_pkg::in_item_t well_formed(logic [17:0] p, logic [7:0] s);
    pict_pkg::in_item_t m;
    logic [7:0]         inst;
    inst = ($urandom_range(99) < 80) ? 8'($urandom_range(3)) : 8'($urandom_range(254));
    m = message_of(p, s, ($urandom_range(99) < 70) ? 8'd8 : 8'($urandom_range(223, 2)),
                   8'($urandom_range(255)), 8'($urandom_range(255)));
    if (p == pict_pkg::PGN_TEMP || p == pict_pkg::PGN_PRESSURE) m.byte1 = inst;
    else m.byte0 = inst;
    return m;
  endfunction

  // unknown pgn, short payload, instance 255 or fully random fields
  function automatic pict_pkg::in_item_t noise_message();
    pict_pkg::in_item_t m;
    m = well_formed(INST_PGNS[$urandom_range(6)], src_pool[$urandom_range(POOL_SIZE - 1)]);
    case ($urandom_range(4))
      0: m.pgn = 18'($urandom_range(18'h3FFFF));
      1: m.data_len = 8'd0;
      2: begin
        m.pgn      = $urandom_range(1) ? pict_pkg::PGN_TEMP : pict_pkg::PGN_PRESSURE;
        m.data_len = 8'd1;
      end
      3: begin
        if (m.pgn == pict_pkg::PGN_TEMP || m.pgn == pict_pkg::PGN_PRESSURE)
          m.byte1 = pict_pkg::INST_NONE;
        else m.byte0 = pict_pkg::INST_NONE;
      end
      default: m = message_of(18'($urandom_range(18'h3FFFF)), 8'($urandom_range(255)),
                              8'($urandom_range(223)), 8'($urandom_range(255)),
                              8'($urandom_range(255)));
    endcase
    return m;
  endfunction

  // offer one item, with random gaps before it, and note it when taken
  task automatic send_message(input pict_pkg::in_item_t m);
    while ($urandom_range(99) < send_gap_pct) begin
      msg_ch.valid = 1'b0;
      @(negedge clk);
    end
    msg_ch.valid = 1'b1;
    msg_ch.data  = m;
    do @(posedge clk); while (!msg_ch.ready);
    board.note_message(m);
    @(negedge clk);
  endtask

  // hold off until every queued report has been matched
  task automatic wait_drained();
    msg_ch.valid = 1'b0;
    while (board.outstanding() != 0) @(negedge clk);
  endtask

  // field extremes, every tracked pgn, short payloads, instance 255, overwrite, groups
  task automatic run_directed();
    bit tp;
    send_message(message_of(18'd0, 8'h00, 8'd0, 8'h00, 8'h00));
    send_message(message_of(18'h3FFFF, 8'hFF, 8'd223, 8'hFF, 8'hFF));
    foreach (INST_PGNS[i]) begin
      tp = (INST_PGNS[i] == pict_pkg::PGN_TEMP) || (INST_PGNS[i] == pict_pkg::PGN_PRESSURE);
      send_message(message_of(INST_PGNS[i], 8'h01, 8'd8, tp ? 8'hFF : 8'h00,
                              tp ? 8'h00 : 8'hFF));
    end
    send_message(message_of(pict_pkg::PGN_ENGINE_DYN, 8'hFE, 8'd1, 8'h00, 8'hFF));
    send_message(message_of(pict_pkg::PGN_TEMP, 8'h80, 8'd1, 8'h00, 8'h00));
    send_message(message_of(pict_pkg::PGN_BATTERY, 8'h80, 8'd0, 8'h00, 8'h00));
    send_message(message_of(pict_pkg::PGN_SWITCH_CTL, 8'h80, 8'd8, pict_pkg::INST_NONE,
                            8'h00));
    send_message(message_of(pict_pkg::PGN_PRESSURE, 8'h80, 8'd8, 8'h03,
                            pict_pkg::INST_NONE));
    send_message(message_of(pict_pkg::PGN_TEMP, 8'hFE, 8'd2, 8'hFF, 8'h00));
    send_message(message_of(pict_pkg::PGN_TEMP + 18'd1, 8'hFE, 8'd8, 8'h00, 8'h00));
    send_message(message_of(pict_pkg::PGN_ENGINE_DYN, 8'h01, 8'd8, 8'hFE, 8'h00));
    send_message(message_of(pict_pkg::PGN_HEADING_CTL, 8'h00, 8'd8, 8'h00, 8'h00));
    send_message(message_of(pict_pkg::PGN_FLUID_LEVEL, 8'h7F, 8'd223, 8'h00, 8'h00));
    send_message(message_of(pict_pkg::PGN_FLUID_LEVEL, 8'h40, 8'd8, 8'h00, 8'h55));
    send_message(message_of(pict_pkg::PGN_PRESSURE, 8'h02, 8'd2, 8'h00, 8'h00));
  endtask

  // fill every free slot, then offer new keys to a full table and a few overwrites
  task automatic fill_and_overflow();
    logic [17:0] p;
    logic [7:0]  s;
    foreach (INST_PGNS[pi])
      foreach (src_pool[si])
        if (board.fill_level() < DEPTH && !board.holds_key(INST_PGNS[pi], src_pool[si]))
          send_message(well_formed(INST_PGNS[pi], src_pool[si]));
    repeat (4) begin
      do begin
        p = INST_PGNS[$urandom_range(6)];
        s = 8'($urandom_range(255));
      end while (board.holds_key(p, s));
      send_message(well_formed(p, s));
    end
    repeat (6)
      send_message(well_formed(INST_PGNS[$urandom_range(6)],
                               src_pool[$urandom_range(POOL_SIZE - 1)]));
  endtask

  // main sequence
  initial begin
    int k;
    rst_n        = 1'b0;
    msg_ch.valid = 1'b0;
    msg_ch.data  = '0;
    send_gap_pct = 0;
    stall_pct    = 0;
    board = new();
    // one source per high nibble keeps the pool distinct
    foreach (src_pool[i]) src_pool[i] = 8'(i * 16 + $urandom_range(15));
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    run_directed();

    // random part in idling phases, draining at each phase change
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        wait_drained();
        case (k / PHASE_LEN)
          0: begin
            send_gap_pct = 0;
            stall_pct    = 0;
          end
          1: begin
            send_gap_pct = 54;
            stall_pct    = 0;
          end
          2: begin
            send_gap_pct = 0;
            stall_pct    = 54;
          end
          default: begin
            send_gap_pct = 22;
            stall_pct    = 22;
          end
        endcase
      end
      if ($urandom_range(99) < 70)
        send_message(well_formed(INST_PGNS[$urandom_range(6)],
                                 src_pool[$urandom_range(POOL_SIZE - 1)]));
      else
        send_message(noise_message());
    end

    fill_and_overflow();

    wait_drained();
    repeat (50) @(negedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
